// ===== hdl/next_lexicographic_permutation_assert.svh =====
// assertion macros used by the permutation datapath module
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH
`define NEXT_LEXICOGRAPHIC_PERMUTATION_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define NLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define NLP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define NLP_ASSERT(lbl, prop, msg)
`define NLP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hdl/nlp_pkg.sv =====
// shared types and constants of the next permutation block
// no dependencies
package nlp_pkg;

  // element width is fixed by the word format
  localparam int ELEM_BITS   = 32;
  localparam int MAX_LEN_DEF = 16;

  // input word
  typedef struct packed {
    logic signed [ELEM_BITS-1:0] elem_value;
    logic                        elem_last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [ELEM_BITS-1:0] out_value;
    logic                        out_last;
  } out_word_t;

  // controller states, one-hot
  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PSCAN = 4'b0010,
    ST_SSCAN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_en;
    logic load_last;
    logic scan_pivot;
    logic scan_succ;
    logic emit_en;
    logic cnt_clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic piv_found;
    logic no_piv;
    logic succ_found;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/nlp_ctrl.sv =====
// controller state machine of the next permutation block
// depends on nlp_pkg
module nlp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  nlp_pkg::stat_t stat,
  output nlp_pkg::cmd_t  cmd,
  output logic           in_stall
);

  nlp_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlp_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      nlp_pkg::ST_LOAD: begin
        cmd.load_en   = in_valid;
        cmd.load_last = in_valid && in_last;
        if (in_valid && in_last) begin
          state_nxt = nlp_pkg::ST_PSCAN;
        end
      end
      nlp_pkg::ST_PSCAN: begin
        cmd.scan_pivot = 1'b1;
        if (stat.no_piv) begin
          state_nxt = nlp_pkg::ST_EMIT;
        end else if (stat.piv_found) begin
          state_nxt = nlp_pkg::ST_SSCAN;
        end
      end
      nlp_pkg::ST_SSCAN: begin
        cmd.scan_succ = 1'b1;
        if (stat.succ_found) begin
          state_nxt = nlp_pkg::ST_EMIT;
        end
      end
      nlp_pkg::ST_EMIT: begin
        cmd.emit_en = stat.out_free;
        if (stat.out_free && stat.emit_last) begin
          cmd.cnt_clear = 1'b1;
          state_nxt     = nlp_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = nlp_pkg::ST_LOAD;
      end
    endcase
  end

  // input taken only while loading
  assign in_stall = (state_r != nlp_pkg::ST_LOAD);

endmodule

// ===== hdl/nlp_dpath.sv =====
// datapath of the next permutation block: element memory, scan pipeline,
// emit address logic and output register; depends on nlp_pkg and the assert header
`include "next_lexicographic_permutation_assert.svh"

module nlp_dpath #(
  parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nlp_pkg::cmd_t     cmd,
  input  nlp_pkg::in_word_t in_data,
  input  logic              out_stall,
  output nlp_pkg::stat_t    stat,
  output logic              out_valid,
  output nlp_pkg::out_word_t out_data
);

  localparam int EB = nlp_pkg::ELEM_BITS;
  localparam int IW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [EB-1:0] mem [MAX_LEN];

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] a_r;
  logic          iss_v_r, qv_r, pv_r;
  logic signed [EB-1:0] scan_q_r, prev_r, piv_val_r;
  logic [IW-1:0] qidx_r, piv_idx_r, succ_idx_r, k_r;
  logic          nopiv_r;
  logic signed [EB-1:0] out_q_r;
  logic          out_last_r, out_valid_r;

  logic          not_full;
  logic          piv_hit, no_piv_hit, succ_hit, restart, scanning;
  logic [CW:0]   mirror_sum;
  logic [CW-1:0] rev_idx;
  logic [IW-1:0] mirror_idx, emit_addr;
  logic          emit_sub;

  assign not_full = (cnt_r < CW'(MAX_LEN));

  // element count; holds the sequence length until the emit ends
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clear) begin
      cnt_nxt = '0;
    end else if (cmd.load_en && not_full) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // memory write port, words past capacity are dropped
  always_ff @(posedge clk) begin
    if (cmd.load_en && not_full) begin
      mem[cnt_r[IW-1:0]] <= in_data.elem_value;
    end
  end

  // scan compares on the registered read data
  assign piv_hit    = qv_r && pv_r && (scan_q_r < prev_r);
  assign no_piv_hit = qv_r && (qidx_r == '0) && !piv_hit;
  assign succ_hit   = qv_r && (piv_val_r < scan_q_r);
  assign restart    = cmd.scan_pivot && piv_hit;
  assign scanning   = cmd.scan_pivot || cmd.scan_succ;

  // scan read port walks down from the top element, one read a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_v_r <= 1'b0;
      qv_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else if (cmd.load_last) begin
      a_r     <= IW'(cnt_nxt - CW'(1));
      iss_v_r <= 1'b1;
      qv_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else if (restart) begin
      a_r     <= IW'(cnt_r - CW'(1));
      iss_v_r <= 1'b1;
      qv_r    <= 1'b0;
      pv_r    <= 1'b0;
    end else if (scanning) begin
      qv_r <= iss_v_r;
      pv_r <= qv_r;
      if (iss_v_r) begin
        a_r <= a_r - IW'(1);
      end
      if (a_r == '0) begin
        iss_v_r <= 1'b0;
      end
    end else begin
      iss_v_r <= 1'b0;
      qv_r    <= 1'b0;
      pv_r    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_q_r <= mem[a_r];
    qidx_r   <= a_r;
    prev_r   <= scan_q_r;
  end

  // pivot, successor and emit counter
  always_ff @(posedge clk) begin
    if (restart) begin
      piv_idx_r <= qidx_r;
      piv_val_r <= scan_q_r;
      nopiv_r   <= 1'b0;
    end
    if (cmd.scan_pivot && no_piv_hit) begin
      nopiv_r <= 1'b1;
    end
    if (cmd.scan_succ && succ_hit) begin
      succ_idx_r <= qidx_r;
    end
    if ((cmd.scan_succ && succ_hit) || (cmd.scan_pivot && no_piv_hit)) begin
      k_r <= '0;
    end else if (cmd.emit_en) begin
      k_r <= k_r + IW'(1);
    end
  end

  // emit address: prefix in place, successor at the pivot, suffix mirrored; whole sequence reversed when no pivot
  assign rev_idx    = cnt_r - CW'(1) - CW'(k_r);
  assign mirror_sum = {1'b0, cnt_r} + (CW+1)'(piv_idx_r) - (CW+1)'(k_r);
  assign mirror_idx = mirror_sum[IW-1:0];

  always_comb begin
    emit_sub = 1'b0;
    priority if (nopiv_r) begin
      emit_addr = rev_idx[IW-1:0];
    end else if (k_r < piv_idx_r) begin
      emit_addr = k_r;
    end else if (k_r == piv_idx_r) begin
      emit_addr = succ_idx_r;
    end else begin
      emit_addr = mirror_idx;
      emit_sub  = (mirror_idx == succ_idx_r);
    end
  end

  // output read port doubles as the output register
  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_q_r    <= emit_sub ? piv_val_r : mem[emit_addr];
      out_last_r <= (CW'(k_r) + CW'(1) == cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_en || (out_valid_r && out_stall);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data.out_value = out_q_r;
  assign out_data.out_last  = out_last_r;

  // status back to the controller
  assign stat.piv_found  = piv_hit;
  assign stat.no_piv     = no_piv_hit;
  assign stat.succ_found = succ_hit;
  assign stat.emit_last  = (CW'(k_r) + CW'(1) == cnt_r);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // checks
  `NLP_ASSERT(a_cnt_bound, cnt_r <= CW'(MAX_LEN), "element count beyond capacity")
  `NLP_ASSERT(a_succ_right, (cmd.scan_succ && succ_hit) |-> (qidx_r > piv_idx_r), "successor not right of pivot")
  `NLP_ASSERT_NEVER(a_emit_empty, cmd.emit_en && (cnt_r == '0), "emit with empty sequence")
  `NLP_ASSERT(a_scan_idle, (cmd.load_last) |=> (qv_r == 1'b0), "stale scan data after load")

endmodule

// ===== hdl/next_lexicographic_permutation.sv =====
// next permutation block: loads one element per cycle, then runs a pivot scan,
// a successor scan and an emit phase; both scans use the single scan read port,
// and no new sequence is taken until the emit ends; synchronous active-low reset
// returns to loading, count zero; depends on nlp_pkg, nlp_ctrl and nlp_dpath
module next_lexicographic_permutation #(
  parameter int MAX_LEN = nlp_pkg::MAX_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nlp_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output nlp_pkg::out_word_t out_data
);

  nlp_pkg::cmd_t  cmd;
  nlp_pkg::stat_t stat;

  // sequencer
  nlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.elem_last),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // storage and scan datapath
  nlp_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
